/* rtl/core/agr_pkg.sv */
// Shared types and constants for the ADC auto-ranging gain controller.
package agr_pkg;

  localparam int SUM_W = 19;
  localparam int ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_HIGH_LIMIT    = 2'd0,
    REG_LOW_LIMIT     = 2'd1,
    REG_MAX_GAIN_LOG2 = 2'd2,
    REG_SETTLE        = 2'd3
  } agr_reg_t;

  typedef enum logic [1:0] {
    STAT_ADJUST   = 2'd0,
    STAT_OK       = 2'd1,
    STAT_OVERFLOW = 2'd2
  } agr_status_t;

  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic [3:0] CHAN_RESET   = 4'd6;
  localparam logic [3:0] CHAN_INVALID = 4'd15;
  localparam logic [3:0] SETTLE_MAX   = 4'd15;

  localparam logic [14:0] HIGH_LIMIT_RST = 15'd32439;
  localparam logic [14:0] LOW_LIMIT_RST  = 15'd13106;
  localparam logic [2:0]  MAX_GAIN_RST   = 3'd5;
  localparam logic [3:0]  SETTLE_RST    = 4'd2;

  typedef struct packed {
    logic [14:0] high_limit;
    logic [14:0] low_limit;
    logic [2:0]  max_gain_log2;
    logic [3:0]  settle_samples;
  } agr_cfg_t;

endpackage

/* rtl/core/agr_cfg.sv */
// APB-style configuration register file for the auto-ranging gain controller.
module agr_cfg import agr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output agr_cfg_t          cfg
);

  agr_cfg_t cfg_r;
  agr_reg_t reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = agr_reg_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.high_limit     <= HIGH_LIMIT_RST;
      cfg_r.low_limit      <= LOW_LIMIT_RST;
      cfg_r.max_gain_log2  <= MAX_GAIN_RST;
      cfg_r.settle_samples <= SETTLE_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_HIGH_LIMIT:    cfg_r.high_limit     <= pwdata[14:0];
        REG_LOW_LIMIT:     cfg_r.low_limit      <= pwdata[14:0];
        REG_MAX_GAIN_LOG2: cfg_r.max_gain_log2  <= pwdata[2:0];
        REG_SETTLE:        cfg_r.settle_samples <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_HIGH_LIMIT:    prdata = {17'd0, cfg_r.high_limit};
      REG_LOW_LIMIT:     prdata = {17'd0, cfg_r.low_limit};
      REG_MAX_GAIN_LOG2: prdata = {29'd0, cfg_r.max_gain_log2};
      REG_SETTLE:        prdata = {28'd0, cfg_r.settle_samples};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

/* rtl/core/adc_auto_gain_ranging_top.sv */
// Top level of the ADC auto-ranging gain controller with moving-sum range checks.
// Each request is captured in an input register and its result is written to the
// output register once that register can take it, which out_ready can hold off.
// One request is accepted every cycle; the only stall comes from out_ready.
// Synchronous active-low reset restores the register defaults, clears the window,
// selects channel 6 at gain one and starts in the settling phase.
module adc_auto_gain_ranging_top import agr_pkg::*; #(
  parameter int WINDOW = 3
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_opcode,
  input  logic signed [15:0]      in_sample,
  input  logic [3:0]              in_channel,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [2:0]              out_gain_log2,
  output logic                    out_gain_changed,
  output logic [3:0]              out_mux_code,
  output logic                    out_mux_changed,
  output logic [1:0]              out_range_status,
  output logic signed [SUM_W-1:0] out_window_sum,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int PtrW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [PtrW-1:0]  PtrLast  = PtrW'(WINDOW - 1);
  localparam logic [SUM_W-1:0] WindowSz = SUM_W'(WINDOW);

  agr_cfg_t cfg;

  agr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic               s1_valid_r;
  logic               s1_opcode_r;
  logic signed [15:0] s1_sample_r;
  logic [3:0]         s1_channel_r;
  logic               advance;
  logic               fire;

  logic signed [15:0]      win_r [WINDOW];
  logic [PtrW-1:0]         ptr_r, ptr_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [3:0]              settle_r, settle_nxt;
  logic                    check_r, check_nxt;
  logic [2:0]              gain_r, gain_nxt;
  logic [3:0]              chan_r, chan_nxt;
  agr_status_t             stat_r, stat_nxt;
  logic                    gchg, mchg, clear, wr_win;

  logic [3:0]              settle_inc;
  logic [3:0]              chan_sel;
  logic signed [SUM_W-1:0] sum_upd;
  logic [SUM_W-1:0]        mag;
  logic [SUM_W-1:0]        hi_lim;
  logic [SUM_W-1:0]        lo_lim;

  logic                    out_valid_r;
  logic [2:0]              out_gain_r;
  logic                    out_gchg_r;
  logic [3:0]              out_mux_r;
  logic                    out_mchg_r;
  agr_status_t             out_stat_r;
  logic signed [SUM_W-1:0] out_sum_r;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;
  assign fire     = s1_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_opcode_r  <= in_opcode;
      s1_sample_r  <= in_sample;
      s1_channel_r <= in_channel;
    end
  end

  assign settle_inc = (settle_r < SETTLE_MAX) ? settle_r + 4'd1 : settle_r;
  assign chan_sel   = (s1_channel_r == CHAN_INVALID) ? 4'd0 : s1_channel_r;
  assign sum_upd    = sum_r - SUM_W'(win_r[ptr_r]) + SUM_W'(s1_sample_r);
  assign mag        = sum_upd[SUM_W-1] ? SUM_W'(-sum_upd) : SUM_W'(sum_upd);
  assign hi_lim     = SUM_W'(WindowSz * {4'd0, cfg.high_limit});
  assign lo_lim     = SUM_W'(WindowSz * {4'd0, cfg.low_limit});

  always_comb begin
    ptr_nxt    = ptr_r;
    sum_nxt    = sum_r;
    settle_nxt = settle_r;
    check_nxt  = check_r;
    gain_nxt   = gain_r;
    chan_nxt   = chan_r;
    stat_nxt   = stat_r;
    gchg       = 1'b0;
    mchg       = 1'b0;
    clear      = 1'b0;
    wr_win     = 1'b0;
    if (s1_opcode_r == OP_RESTART) begin
      if (chan_sel != chan_r) begin
        chan_nxt = chan_sel;
        mchg     = 1'b1;
      end
      check_nxt  = 1'b0;
      settle_nxt = 4'd0;
      stat_nxt   = STAT_ADJUST;
      clear      = 1'b1;
    end else begin
      wr_win     = 1'b1;
      sum_nxt    = sum_upd;
      ptr_nxt    = (ptr_r == PtrLast) ? '0 : ptr_r + PtrW'(1);
      settle_nxt = settle_inc;
      if (!check_r) begin
        if (settle_inc >= cfg.settle_samples) begin
          check_nxt = 1'b1;
          stat_nxt  = STAT_ADJUST;
        end
      end else begin
        if (mag > hi_lim) begin
          if (gain_r != 3'd0) begin
            gain_nxt = gain_r - 3'd1;
            gchg     = 1'b1;
          end else begin
            stat_nxt = STAT_OVERFLOW;
          end
        end else if (mag < lo_lim) begin
          if (gain_r < cfg.max_gain_log2) begin
            gain_nxt = gain_r + 3'd1;
            gchg     = 1'b1;
          end else begin
            stat_nxt = STAT_OK;
          end
        end else begin
          stat_nxt = STAT_OK;
        end
        if (gchg) begin
          check_nxt  = 1'b0;
          settle_nxt = 4'd0;
          clear      = 1'b1;
        end
      end
    end
    if (clear) begin
      ptr_nxt = '0;
      sum_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) begin
        win_r[i] <= '0;
      end
      ptr_r    <= '0;
      sum_r    <= '0;
      settle_r <= 4'd0;
      check_r  <= 1'b0;
      gain_r   <= 3'd0;
      chan_r   <= CHAN_RESET;
      stat_r   <= STAT_ADJUST;
    end else if (fire) begin
      if (clear) begin
        for (int i = 0; i < WINDOW; i++) begin
          win_r[i] <= '0;
        end
      end else if (wr_win) begin
        win_r[ptr_r] <= s1_sample_r;
      end
      ptr_r    <= ptr_nxt;
      sum_r    <= sum_nxt;
      settle_r <= settle_nxt;
      check_r  <= check_nxt;
      gain_r   <= gain_nxt;
      chan_r   <= chan_nxt;
      stat_r   <= stat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_gain_r <= gain_nxt;
      out_gchg_r <= gchg;
      out_mux_r  <= chan_nxt;
      out_mchg_r <= mchg;
      out_stat_r <= stat_nxt;
      out_sum_r  <= sum_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_gain_log2    = out_gain_r;
  assign out_gain_changed = out_gchg_r;
  assign out_mux_code     = out_mux_r;
  assign out_mux_changed  = out_mchg_r;
  assign out_range_status = out_stat_r;
  assign out_window_sum   = out_sum_r;

endmodule

/* bench/adc_auto_gain_ranging_top_tb.sv */
// Self-checking testbench for the ADC auto-ranging gain controller top level.
`timescale 1ns / 100ps

module adc_auto_gain_ranging_top_tb;
  import agr_pkg::*;

  localparam int WINDOW = 3;

  typedef struct {
    logic [2:0]              gain_log2;
    logic                    gain_changed;
    logic [3:0]              mux_code;
    logic                    mux_changed;
    agr_status_t             status;
    logic signed [SUM_W-1:0] window_sum;
  } ranging_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    in_opcode = OP_SAMPLE;
  logic signed [15:0]      in_sample = '0;
  logic [3:0]              in_channel = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [2:0]              out_gain_log2;
  logic                    out_gain_changed;
  logic [3:0]              out_mux_code;
  logic                    out_mux_changed;
  logic [1:0]              out_range_status;
  logic signed [SUM_W-1:0] out_window_sum;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [ADDR_W-1:0]       paddr = '0;
  logic [31:0]             pwdata = '0;
  logic [31:0]             prdata;
  logic                    pready;

  ranging_t pending_ranging[$];
  int       mismatch_cnt = 0;
  bit       idle_on = 1'b1;
  bit       stall_on = 1'b1;

  agr_cfg_t                cfg = '{HIGH_LIMIT_RST, LOW_LIMIT_RST, MAX_GAIN_RST, SETTLE_RST};
  logic signed [15:0]      win_store [WINDOW] = '{default: '0};
  int                      win_ptr = 0;
  logic signed [SUM_W-1:0] win_sum = '0;
  logic [3:0]              settle_cnt = '0;
  logic                    checking = 1'b0;
  logic [2:0]              gain = '0;
  logic [3:0]              sel_chan = CHAN_RESET;
  agr_status_t             status = STAT_ADJUST;

  adc_auto_gain_ranging_top #(.WINDOW(WINDOW)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_opcode(in_opcode),
    .in_sample(in_sample), .in_channel(in_channel),
    .out_valid(out_valid), .out_ready(out_ready), .out_gain_log2(out_gain_log2),
    .out_gain_changed(out_gain_changed), .out_mux_code(out_mux_code),
    .out_mux_changed(out_mux_changed), .out_range_status(out_range_status),
    .out_window_sum(out_window_sum),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void clear_window();
    win_store = '{default: '0};
    win_ptr = 0;
    win_sum = '0;
  endfunction

  function automatic ranging_t predict_ranging(logic op, logic signed [15:0] smp,
                                               logic [3:0] ch);
    ranging_t   e;
    logic [3:0] code;
    int         mag;
    e.gain_changed = 1'b0;
    e.mux_changed = 1'b0;
    if (op == OP_RESTART) begin
      code = (ch == CHAN_INVALID) ? 4'd0 : ch;
      if (code != sel_chan) begin
        sel_chan = code;
        e.mux_changed = 1'b1;
      end
      checking = 1'b0;
      settle_cnt = '0;
      status = STAT_ADJUST;
      clear_window();
    end else begin
      win_sum = win_sum - win_store[win_ptr] + smp;
      win_store[win_ptr] = smp;
      win_ptr = (win_ptr + 1 >= WINDOW) ? 0 : win_ptr + 1;
      if (settle_cnt < SETTLE_MAX) settle_cnt++;
      if (!checking) begin
        if (settle_cnt >= cfg.settle_samples) begin
          checking = 1'b1;
          status = STAT_ADJUST;
        end
      end else begin
        mag = (win_sum < 0) ? -int'(win_sum) : int'(win_sum);
        if (mag > WINDOW * int'(cfg.high_limit)) begin
          if (gain != 3'd0) begin
            gain--;
            e.gain_changed = 1'b1;
          end else begin
            status = STAT_OVERFLOW;
          end
        end else if (mag < WINDOW * int'(cfg.low_limit)) begin
          if (gain < cfg.max_gain_log2) begin
            gain++;
            e.gain_changed = 1'b1;
          end else begin
            status = STAT_OK;
          end
        end else begin
          status = STAT_OK;
        end
        if (e.gain_changed) begin
          checking = 1'b0;
          settle_cnt = '0;
          clear_window();
        end
      end
    end
    e.gain_log2 = gain;
    e.mux_code = sel_chan;
    e.status = status;
    e.window_sum = win_sum;
    return e;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
  endfunction

  initial begin
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      if (stall_on) begin
        out_ready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_results
    ranging_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_ranging.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: gain %0d mux %0d status %0d sum %0d",
                   out_gain_log2, out_mux_code, out_range_status, out_window_sum);
      end else begin
        e = pending_ranging.pop_front();
        if (out_gain_log2 !== e.gain_log2 || out_gain_changed !== e.gain_changed ||
            out_mux_code !== e.mux_code || out_mux_changed !== e.mux_changed ||
            out_range_status !== e.status || out_window_sum !== e.window_sum) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch at %0t: expected gain %0d/%0b mux %0d/%0b status %0d sum %0d",
                     $realtime, e.gain_log2, e.gain_changed, e.mux_code, e.mux_changed,
                     e.status, e.window_sum);
            $display("  got gain %0d/%0b mux %0d/%0b status %0d sum %0d",
                     out_gain_log2, out_gain_changed, out_mux_code, out_mux_changed,
                     out_range_status, out_window_sum);
          end
        end
      end
    end
  end

  task automatic send_item(logic op, logic signed [15:0] smp, logic [3:0] ch);
    int gap;
    gap = (idle_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_sample <= smp;
    in_channel <= ch;
    do @(posedge clk); while (!in_ready);
    pending_ranging.push_back(predict_ranging(op, smp, ch));
  endtask

  task automatic sample_in(int v);
    send_item(OP_SAMPLE, 16'(v), 4'($urandom));
  endtask

  task automatic restart_in(logic [3:0] ch);
    send_item(OP_RESTART, 16'($urandom), ch);
  endtask

  task automatic settle_idle();
    in_valid <= 1'b0;
    while (pending_ranging.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(agr_reg_t idx, logic [31:0] val);
    settle_idle();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_HIGH_LIMIT:    cfg.high_limit = val[14:0];
      REG_LOW_LIMIT:     cfg.low_limit = val[14:0];
      REG_MAX_GAIN_LOG2: cfg.max_gain_log2 = val[2:0];
      REG_SETTLE:        cfg.settle_samples = val[3:0];
      default: ;
    endcase
  endtask

  task automatic test_channel_restart();
    restart_in(CHAN_RESET);
    restart_in(CHAN_INVALID);
    restart_in(4'd0);
    restart_in(4'd14);
  endtask

  // Full-scale positive overflows at gain one, then a sum below the low limit raises
  // the gain and a full-scale negative window lowers it again.
  task automatic test_full_scale();
    repeat (3) sample_in(32767);
    repeat (4) sample_in(-32768);
  endtask

  // A zero settle count behaves like one; the gain climbs to its ceiling and
  // then stays put when the ceiling is lowered beneath it.
  task automatic test_gain_ceiling();
    write_reg(REG_SETTLE, 32'd0);
    repeat (12) sample_in(0);
    write_reg(REG_MAX_GAIN_LOG2, 32'd2);
    sample_in(1);
    sample_in(-1);
  endtask

  task automatic test_random_setting(logic [14:0] hi, logic [14:0] lo, logic [2:0] mx,
                                     logic [3:0] st, int n);
    int lvl, left, r, v;
    left = 0;
    lvl = 0;
    write_reg(REG_HIGH_LIMIT, 32'(hi));
    write_reg(REG_LOW_LIMIT, 32'(lo));
    write_reg(REG_MAX_GAIN_LOG2, 32'(mx));
    write_reg(REG_SETTLE, 32'(st));
    for (int i = 0; i < n; i++) begin
      if (i % 48 == 0) begin
        idle_on = ($urandom_range(0, 3) != 0);
        stall_on = ($urandom_range(0, 3) != 0);
      end
      r = $urandom_range(0, 99);
      if (r < 5) begin
        restart_in(4'($urandom));
      end else if (r < 9) begin
        send_item(OP_SAMPLE, 16'($urandom), 4'($urandom));
      end else begin
        if (left == 0) begin
          case ($urandom_range(0, 5))
            0: lvl = 32767;
            1: lvl = int'(cfg.high_limit) + 2;
            2: lvl = int'(cfg.high_limit) - 2;
            3: lvl = int'(cfg.low_limit);
            4: lvl = 0;
            default: lvl = $urandom_range(0, 32767);
          endcase
          left = $urandom_range(3, 12);
        end
        left--;
        v = ($urandom_range(0, 3) == 0) ? lvl : lvl + int'($urandom_range(0, 127)) - 64;
        if ($urandom_range(0, 1) == 1) v = -v;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        sample_in(v);
      end
    end
  endtask

  task automatic finish_run();
    settle_idle();
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_channel_restart();
    test_full_scale();
    test_gain_ceiling();
    test_random_setting(15'd32767, 15'd0, 3'd0, 4'd1, 100);
    test_random_setting(15'd0, 15'd32767, 3'd7, 4'd15, 90);
    test_random_setting(15'd0, 15'd0, 3'd7, 4'd1, 60);
    test_random_setting(HIGH_LIMIT_RST, LOW_LIMIT_RST, MAX_GAIN_RST, SETTLE_RST, 160);
    test_random_setting(15'd16000, 15'd8000, 3'd3, 4'd3, 100);
    repeat (2)
      test_random_setting(15'($urandom), 15'($urandom), 3'($urandom),
                          4'($urandom_range(1, 15)), 90);
    finish_run();
  end

  initial begin
    #400_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
